@@ rtl/core/gab2d_pkg.sv @@
// shared types, codes and constants of the gab2 subtitle chunk deframer
// no dependencies; used by every module of the block
package gab2d_pkg;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_NAME,
		PH_LENGTHS,
		PH_FILE,
		PH_PAD
	} phase_t;

	localparam logic [2:0] STAT_OK       = 3'd0;
	localparam logic [2:0] STAT_MAGIC    = 3'd1;
	localparam logic [2:0] STAT_NAME_OVR = 3'd2;
	localparam logic [2:0] STAT_FIXED    = 3'd3;
	localparam logic [2:0] STAT_TRUNC    = 3'd4;
	localparam logic [2:0] STAT_EXTRA    = 3'd5;

	localparam logic       KIND_BYTE   = 1'b0;
	localparam logic       KIND_STATUS = 1'b1;

	localparam logic [15:0] FIXED_WORD = 16'h0004;
	localparam logic [7:0]  BOM_0      = 8'hEF;
	localparam logic [7:0]  BOM_1      = 8'hBB;
	localparam logic [7:0]  BOM_2      = 8'hBF;

	localparam logic [3:0] MAGIC_LEN  = 4'd7;
	localparam logic [3:0] HEADER_END = 4'd10;
	localparam logic [2:0] LENGTH_END = 3'd5;

	// results one item can cause
	localparam int unsigned MAX_RES = 4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       chunk_end;
	} item_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] value;
		logic       file_last;
		logic [2:0] status;
	} res_t;

	typedef struct packed {
		res_t [MAX_RES-1:0] slot;
		logic [2:0]         count;
	} bundle_t;

	function automatic logic [7:0] magic_byte(input logic [2:0] idx);
		logic [7:0] m;
		unique case (idx)
			3'd0:    m = 8'h47;
			3'd1:    m = 8'h41;
			3'd2:    m = 8'h42;
			3'd3:    m = 8'h32;
			3'd4:    m = 8'h00;
			3'd5:    m = 8'h02;
			3'd6:    m = 8'h00;
			default: m = 8'h00;
		endcase
		return m;
	endfunction

	function automatic res_t mk_res(input logic kind, input logic [7:0] value,
		input logic file_last, input logic [2:0] status);
		res_t r;
		r.kind      = kind;
		r.value     = value;
		r.file_last = file_last;
		r.status    = status;
		return r;
	endfunction

endpackage

@@ rtl/core/gab2d_if.sv @@
// valid/ready channel interfaces of the deframer: chunk bytes in, results out
// no dependencies
interface gab2d_chunk_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       chunk_end;

	modport source(output valid, output data_byte, output chunk_end, input ready);
	modport sink(input valid, input data_byte, input chunk_end, output ready);
endinterface

interface gab2d_result_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] value;
	logic       file_last;
	logic [2:0] status;

	modport source(output valid, output kind, output value, output file_last,
		output status, input ready);
	modport sink(input valid, input kind, input value, input file_last,
		input status, output ready);
endinterface

@@ rtl/core/gab2d_in_reg.sv @@
// input register: holds one accepted chunk byte until the parser takes it
// depends on gab2d_pkg and gab2d_chunk_if
module gab2d_in_reg (
	input  logic             clk,
	input  logic             arst_n,
	gab2d_chunk_if.sink      chunk,
	input  logic             consume,
	output logic             valid_s1,
	output gab2d_pkg::item_t item_s1
);
	import gab2d_pkg::*;

	assign chunk.ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chunk.ready) begin
			valid_s1 <= chunk.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chunk.valid && chunk.ready) begin
			item_s1.data_byte <= chunk.data_byte;
			item_s1.chunk_end <= chunk.chunk_end;
		end
	end

endmodule

@@ rtl/core/gab2d_parse.sv @@
// chunk parser: phase tracking, header capture, mark stripping and status
// depends on gab2d_pkg; builds the result bundle for one item
module gab2d_parse (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               consume,
	input  gab2d_pkg::item_t   item_s1,
	output gab2d_pkg::bundle_t bundle
);
	import gab2d_pkg::*;

	phase_t      phase_q, phase_d;
	logic [31:0] cnt_q, cnt_d;
	logic [31:0] name_q, name_d;
	logic [31:0] file_q, file_d;
	logic [15:0] fixed_q, fixed_d;
	logic        magic_bad_q, magic_bad_d;
	logic [15:0] hold_q, hold_d;
	logic [1:0]  mcount_q, mcount_d;
	logic        taken_q, taken_d;

	logic [7:0]  b;
	logic        e;
	logic [31:0] name_full;
	logic [31:0] file_full;
	logic        last_b;
	logic        stream_ok;
	logic [1:0]  nsel;
	logic [1:0]  fsel;

	assign b         = item_s1.data_byte;
	assign e         = item_s1.chunk_end;
	assign name_full = {b, name_q[23:0]};
	assign file_full = {b, file_q[23:0]};
	assign last_b    = ({1'b0, cnt_q} + 33'd1) == {1'b0, file_q};
	assign stream_ok = !magic_bad_q && (fixed_q == FIXED_WORD);
	assign nsel      = 2'(cnt_q[3:0] - MAGIC_LEN);
	assign fsel      = 2'(cnt_q[2:0] - 3'd2);

	// next phase and position counter
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		if (e) begin
			phase_d = PH_HEADER;
			cnt_d   = '0;
		end else if (!taken_q) begin
			unique case (phase_q)
				PH_HEADER: begin
					if (cnt_q[3:0] == HEADER_END) begin
						if (name_full == '0) begin
							phase_d = PH_LENGTHS;
							cnt_d   = '0;
						end else begin
							phase_d = PH_NAME;
							cnt_d   = name_full;
						end
					end else begin
						cnt_d = cnt_q + 32'd1;
					end
				end
				PH_NAME: begin
					// counts the remaining name bytes down
					if (cnt_q == 32'd1) begin
						phase_d = PH_LENGTHS;
						cnt_d   = '0;
					end else begin
						cnt_d = cnt_q - 32'd1;
					end
				end
				PH_LENGTHS: begin
					if (cnt_q[2:0] == LENGTH_END) begin
						phase_d = (file_full == '0) ? PH_PAD : PH_FILE;
						cnt_d   = '0;
					end else begin
						cnt_d = cnt_q + 32'd1;
					end
				end
				PH_FILE: begin
					if (last_b) begin
						phase_d = PH_PAD;
					end else begin
						cnt_d = cnt_q + 32'd1;
					end
				end
				PH_PAD: begin
				end
				default: begin
					phase_d = PH_HEADER;
				end
			endcase
		end
	end

	// field capture and result bundle
	always_comb begin
		logic [2:0] n;
		logic [2:0] st;
		name_d      = name_q;
		file_d      = file_q;
		fixed_d     = fixed_q;
		magic_bad_d = magic_bad_q;
		hold_d      = hold_q;
		mcount_d    = mcount_q;
		taken_d     = taken_q;
		n           = '0;
		st          = STAT_OK;
		bundle.slot = '0;

		if (!taken_q) begin
			unique case (phase_q)
				PH_HEADER: begin
					if (cnt_q[3:0] < MAGIC_LEN) begin
						if (b != magic_byte(cnt_q[2:0])) begin
							magic_bad_d = 1'b1;
						end
					end else begin
						name_d[8*nsel +: 8] = b;
					end
				end
				PH_LENGTHS: begin
					if (cnt_q[2:0] < 3'd2) begin
						fixed_d[8*cnt_q[0] +: 8] = b;
					end else begin
						file_d[8*fsel +: 8] = b;
					end
				end
				PH_FILE: begin
					if (stream_ok) begin
						if (file_q >= 32'd3 && cnt_q < 32'd2) begin
							// first two bytes wait for a possible mark
							hold_d[8*cnt_q[0] +: 8] = b;
							mcount_d = cnt_q[0] ? 2'd2 : 2'd1;
						end else if (file_q >= 32'd3 && cnt_q == 32'd2) begin
							if (!(hold_q == {BOM_1, BOM_0} && b == BOM_2)) begin
								bundle.slot[n[1:0]] = mk_res(KIND_BYTE, hold_q[7:0], 1'b0, STAT_OK);
								n = n + 3'd1;
								bundle.slot[n[1:0]] = mk_res(KIND_BYTE, hold_q[15:8], 1'b0, STAT_OK);
								n = n + 3'd1;
								bundle.slot[n[1:0]] = mk_res(KIND_BYTE, b, last_b, STAT_OK);
								n = n + 3'd1;
							end
							hold_d   = '0;
							mcount_d = '0;
						end else begin
							bundle.slot[n[1:0]] = mk_res(KIND_BYTE, b, last_b, STAT_OK);
							n = n + 3'd1;
						end
					end
				end
				default: begin
				end
			endcase
		end

		if (e) begin
			// held bytes go out ahead of the status
			if (mcount_d >= 2'd1) begin
				bundle.slot[n[1:0]] = mk_res(KIND_BYTE, hold_d[7:0], 1'b0, STAT_OK);
				n = n + 3'd1;
			end
			if (mcount_d >= 2'd2) begin
				bundle.slot[n[1:0]] = mk_res(KIND_BYTE, hold_d[15:8], 1'b0, STAT_OK);
				n = n + 3'd1;
			end
			if (taken_q) begin
				st = STAT_EXTRA;
			end else begin
				unique case (phase_q)
					PH_HEADER: st = STAT_MAGIC;
					PH_NAME, PH_LENGTHS: st = magic_bad_d ? STAT_MAGIC : STAT_NAME_OVR;
					PH_FILE, PH_PAD: begin
						priority if (magic_bad_d) st = STAT_MAGIC;
						else if (fixed_q != FIXED_WORD) st = STAT_FIXED;
						else if (phase_q == PH_FILE && !last_b) st = STAT_TRUNC;
						else st = STAT_OK;
					end
					default: st = STAT_MAGIC;
				endcase
			end
			bundle.slot[n[1:0]] = mk_res(KIND_STATUS, 8'h00, 1'b0, st);
			n = n + 3'd1;
			if (st == STAT_OK) begin
				taken_d = 1'b1;
			end
			name_d      = '0;
			file_d      = '0;
			fixed_d     = '0;
			magic_bad_d = 1'b0;
			hold_d      = '0;
			mcount_d    = '0;
		end
		bundle.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			cnt_q       <= '0;
			name_q      <= '0;
			file_q      <= '0;
			fixed_q     <= '0;
			magic_bad_q <= 1'b0;
			hold_q      <= '0;
			mcount_q    <= '0;
			taken_q     <= 1'b0;
		end else if (consume) begin
			phase_q     <= phase_d;
			cnt_q       <= cnt_d;
			name_q      <= name_d;
			file_q      <= file_d;
			fixed_q     <= fixed_d;
			magic_bad_q <= magic_bad_d;
			hold_q      <= hold_d;
			mcount_q    <= mcount_d;
			taken_q     <= taken_d;
		end
	end

endmodule

@@ rtl/core/gab2d_out_buf.sv @@
// result register: holds one item's results, hands them out one per cycle
// while result.ready is high; depends on gab2d_pkg and gab2d_result_if
module gab2d_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  gab2d_pkg::bundle_t bundle,
	input  logic               load,
	output logic               load_ok,
	gab2d_result_if.source     result
);
	import gab2d_pkg::*;

	res_t [MAX_RES-1:0] slot_q;
	logic [2:0]         rem_q;
	logic [1:0]         idx_q;
	logic               pop;
	res_t               head;

	assign head             = slot_q[idx_q];
	assign result.valid     = rem_q != 3'd0;
	assign result.kind      = head.kind;
	assign result.value     = head.value;
	assign result.file_last = head.file_last;
	assign result.status    = head.status;
	assign pop              = result.valid && result.ready;
	// free now, or the last result leaves this cycle
	assign load_ok          = (rem_q == 3'd0) || (rem_q == 3'd1 && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			rem_q <= bundle.count;
			idx_q <= '0;
		end else if (pop) begin
			rem_q <= rem_q - 3'd1;
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= bundle.slot;
		end
	end

endmodule

@@ rtl/core/gab2_subtitle_chunk_deframer.sv @@
// gab2 subtitle chunk deframer: chunk bytes in, file bytes and status out
// path: an accepted byte enters the input register, its results the result register
// throughput: one byte per cycle while result.ready is high; an item with more
//   results holds the input while the result register drains them one a cycle
// reset: arst_n clears the chunk parser to the header phase and the refusal flag
// depends on gab2d_pkg, gab2d_if, gab2d_in_reg, gab2d_parse, gab2d_out_buf
module gab2_subtitle_chunk_deframer (
	input  logic           clk,
	input  logic           arst_n,
	gab2d_chunk_if.sink    chunk,
	gab2d_result_if.source result
);
	import gab2d_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	bundle_t bundle;
	logic    load_ok;
	logic    consume;

	assign consume = valid_s1 && load_ok;

	gab2d_in_reg u_in_reg (
		.clk     (clk),
		.arst_n  (arst_n),
		.chunk   (chunk),
		.consume (consume),
		.valid_s1(valid_s1),
		.item_s1 (item_s1)
	);

	gab2d_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.consume(consume),
		.item_s1(item_s1),
		.bundle (bundle)
	);

	gab2d_out_buf u_out_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.bundle (bundle),
		.load   (consume),
		.load_ok(load_ok),
		.result (result)
	);

endmodule

@@ bench/tb_gab2_subtitle_chunk_deframer.sv @@
// testbench of the gab2 subtitle chunk deframer: directed table, then random chunks
// checked against a cycle-free model of the parser; depends on gab2d_pkg, gab2d_if
// and the rtl top gab2_subtitle_chunk_deframer
module tb_gab2_subtitle_chunk_deframer;
	import gab2d_pkg::*;

	localparam logic [55:0] CHUNK_MAGIC  = 56'h47_41_42_32_00_02_00;
	localparam logic [35:0] MAGIC_BYTES  = 36'd7;
	localparam logic [35:0] NAME_LEN_END = 36'd11;
	localparam logic [35:0] FIXED_END    = 36'd13;
	localparam logic [35:0] HDR_BYTES    = 36'd17;
	localparam logic [35:0] MIN_CHUNK    = 36'd12;
	localparam int          DIR_ROWS     = 25;
	localparam int          RAND_ITEMS   = 480;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       chunk_end;
		logic       typed;
		logic [2:0] status;
	} dir_row_t;

	logic clk;
	logic arst_n;

	gab2d_chunk_if  chunk_ch();
	gab2d_result_if result_ch();

	gab2_subtitle_chunk_deframer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chunk  (chunk_ch),
		.result (result_ch)
	);

	// model state
	phase_t      ph;
	logic [33:0] pos;
	logic [31:0] name_len;
	logic [31:0] file_len;
	logic [15:0] fixed_seen;
	logic        magic_err;
	logic [15:0] bom_hold;
	logic [1:0]  bom_cnt;
	logic        chunk_taken;

	res_t        step_results[$];
	res_t        pending_results[$];
	logic [7:0]  chunk_q[$];

	int          errors = 0;
	int          sent_items = 0;
	int          burst_left = 0;
	int          stall_cyc = 0;
	int          stall_mode = 0;
	res_t        want;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic dir_row_t dir_row(input int i);
		dir_row_t r;
		case (i)
			0:       r = {8'hFF, 1'b1, 1'b1, STAT_MAGIC};
			1:       r = {8'h00, 1'b1, 1'b1, STAT_MAGIC};
			// good magic, then a chunk end inside the name length
			2:       r = {8'h47, 1'b0, 1'b0, STAT_OK};
			3:       r = {8'h41, 1'b0, 1'b0, STAT_OK};
			4:       r = {8'h42, 1'b0, 1'b0, STAT_OK};
			5:       r = {8'h32, 1'b0, 1'b0, STAT_OK};
			6:       r = {8'h00, 1'b0, 1'b0, STAT_OK};
			7:       r = {8'h02, 1'b0, 1'b0, STAT_OK};
			8:       r = {8'h00, 1'b0, 1'b0, STAT_OK};
			9:       r = {8'hFF, 1'b0, 1'b0, STAT_OK};
			10:      r = {8'hFF, 1'b0, 1'b0, STAT_OK};
			11:      r = {8'hFF, 1'b0, 1'b0, STAT_OK};
			12:      r = {8'hFF, 1'b1, 1'b1, STAT_MAGIC};
			// twelve bytes with an empty name: overruns
			13:      r = {8'h47, 1'b0, 1'b0, STAT_OK};
			14:      r = {8'h41, 1'b0, 1'b0, STAT_OK};
			15:      r = {8'h42, 1'b0, 1'b0, STAT_OK};
			16:      r = {8'h32, 1'b0, 1'b0, STAT_OK};
			17:      r = {8'h00, 1'b0, 1'b0, STAT_OK};
			18:      r = {8'h02, 1'b0, 1'b0, STAT_OK};
			19:      r = {8'h00, 1'b0, 1'b0, STAT_OK};
			20:      r = {8'h00, 1'b0, 1'b0, STAT_OK};
			21:      r = {8'h00, 1'b0, 1'b0, STAT_OK};
			22:      r = {8'h00, 1'b0, 1'b0, STAT_OK};
			23:      r = {8'h00, 1'b0, 1'b0, STAT_OK};
			default: r = {8'h04, 1'b1, 1'b1, STAT_NAME_OVR};
		endcase
		return r;
	endfunction

	task automatic add_result(input logic kind, input logic [7:0] value,
		input logic file_last, input logic [2:0] status);
		res_t r;
		r.kind      = kind;
		r.value     = value;
		r.file_last = file_last;
		r.status    = status;
		step_results.push_back(r);
	endtask

	task automatic clear_chunk_state();
		ph         = PH_HEADER;
		pos        = '0;
		name_len   = '0;
		file_len   = '0;
		fixed_seen = '0;
		magic_err  = 1'b0;
		bom_hold   = '0;
		bom_cnt    = '0;
	endtask

	// file byte with byte-order mark handling
	task automatic file_out(input logic [35:0] idx, input logic [7:0] b);
		if (file_len >= 32'd3 && idx < 36'd2) begin
			bom_hold = bom_hold | ({8'h00, b} << (8 * idx));
			bom_cnt  = idx[1:0] + 2'd1;
		end else if (file_len >= 32'd3 && idx == 36'd2) begin
			if (!(bom_hold == {BOM_1, BOM_0} && b == BOM_2)) begin
				add_result(KIND_BYTE, bom_hold[7:0], 1'b0, STAT_OK);
				add_result(KIND_BYTE, bom_hold[15:8], 1'b0, STAT_OK);
				add_result(KIND_BYTE, b, file_len == 32'd3, STAT_OK);
			end
			bom_hold = '0;
			bom_cnt  = '0;
		end else begin
			add_result(KIND_BYTE, b, idx == {4'h0, file_len} - 36'd1, STAT_OK);
		end
	endtask

	task automatic deframe_predict(input logic [7:0] b, input logic e);
		logic [35:0] p;
		logic [35:0] nn;
		logic [35:0] ff;
		logic [35:0] sz;
		logic [2:0]  st;
		p  = {2'b00, pos};
		nn = {4'h0, name_len};
		if (!chunk_taken) begin
			if (p < MAGIC_BYTES) begin
				ph = PH_HEADER;
				if (b != CHUNK_MAGIC[55 - 8 * p[2:0] -: 8])
					magic_err = 1'b1;
			end else if (p < NAME_LEN_END) begin
				ph = PH_HEADER;
				name_len = name_len | ({24'h0, b} << (8 * (p - MAGIC_BYTES)));
			end else if (p < NAME_LEN_END + nn) begin
				ph = PH_NAME;
			end else if (p < FIXED_END + nn) begin
				ph = PH_LENGTHS;
				fixed_seen = fixed_seen | ({8'h00, b} << (8 * (p - NAME_LEN_END - nn)));
			end else if (p < HDR_BYTES + nn) begin
				ph = PH_LENGTHS;
				file_len = file_len | ({24'h0, b} << (8 * (p - FIXED_END - nn)));
			end else if (p - HDR_BYTES - nn < {4'h0, file_len}) begin
				ph = PH_FILE;
				if (!magic_err && fixed_seen == FIXED_WORD)
					file_out(p - HDR_BYTES - nn, b);
			end else begin
				ph = PH_PAD;
			end
		end
		if (!e) begin
			if (pos != '1)
				pos = pos + 34'd1;
		end else begin
			sz = p + 36'd1;
			nn = {4'h0, name_len};
			ff = {4'h0, file_len};
			// bytes still held for the mark check go out before the status
			if (bom_cnt >= 2'd1)
				add_result(KIND_BYTE, bom_hold[7:0], 1'b0, STAT_OK);
			if (bom_cnt >= 2'd2)
				add_result(KIND_BYTE, bom_hold[15:8], 1'b0, STAT_OK);
			if (chunk_taken)
				st = STAT_EXTRA;
			else if (magic_err || sz < MIN_CHUNK)
				st = STAT_MAGIC;
			else if (sz <= HDR_BYTES + nn)
				st = STAT_NAME_OVR;
			else if (fixed_seen != FIXED_WORD)
				st = STAT_FIXED;
			else if (sz < HDR_BYTES + nn + ff)
				st = STAT_TRUNC;
			else
				st = STAT_OK;
			add_result(KIND_STATUS, 8'h00, 1'b0, st);
			if (st == STAT_OK)
				chunk_taken = 1'b1;
			clear_chunk_state();
		end
	endtask

	task automatic send_item(input logic [7:0] b, input logic e, input logic typed,
		input logic [2:0] st);
		res_t r;
		if (burst_left == 0) begin
			chunk_ch.valid <= 1'b0;
			repeat (($urandom_range(0, 7) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 4))
				@(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 20);
		end
		chunk_ch.valid     <= 1'b1;
		chunk_ch.data_byte <= b;
		chunk_ch.chunk_end <= e;
		do
			@(posedge clk);
		while (!chunk_ch.ready);
		burst_left--;
		sent_items++;
		deframe_predict(b, e);
		if (typed) begin
			step_results.delete();
			r.kind      = KIND_STATUS;
			r.value     = 8'h00;
			r.file_last = 1'b0;
			r.status    = st;
			pending_results.push_back(r);
		end else begin
			while (step_results.size() != 0)
				pending_results.push_back(step_results.pop_front());
		end
	endtask

	task automatic send_chunk();
		for (int i = 0; i < chunk_q.size(); i++)
			send_item(chunk_q[i], i == chunk_q.size() - 1, 1'b0, STAT_OK);
	endtask

	// one chunk into chunk_q; without want_ok it is always broken somewhere
	task automatic build_chunk(input bit want_ok);
		logic [31:0] nlen;
		logic [31:0] flen;
		logic [7:0]  bv;
		bit          big_name;
		bit          big_file;
		int          nreal;
		int          freal;
		int          bom_mode;
		int          fault;
		int          cut;
		int          idx;
		chunk_q.delete();
		if (!want_ok && $urandom_range(0, 99) < 8) begin
			repeat ($urandom_range(1, 20))
				chunk_q.push_back(8'($urandom));
			return;
		end
		big_name = !want_ok && $urandom_range(0, 9) == 0;
		big_file = !want_ok && !big_name && $urandom_range(0, 9) == 0;
		if (big_name)
			nlen = $urandom | 32'h1000_0000;
		else if ($urandom_range(0, 9) < 7)
			nlen = $urandom_range(0, 4);
		else
			nlen = $urandom_range(5, 20);
		if (big_file)
			flen = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'h8000_0000);
		else begin
			fault = $urandom_range(0, 9);
			if (fault < 4)
				flen = $urandom_range(3, 10);
			else if (fault < 6)
				flen = $urandom_range(0, 2);
			else
				flen = $urandom_range(11, 24);
		end
		for (int i = 0; i < 7; i++)
			chunk_q.push_back(CHUNK_MAGIC[55 - 8 * i -: 8]);
		for (int i = 0; i < 4; i++)
			chunk_q.push_back(nlen[8 * i +: 8]);
		if (big_name) begin
			repeat ($urandom_range(0, 10))
				chunk_q.push_back(8'($urandom));
			return;
		end
		nreal = nlen;
		repeat (nreal)
			chunk_q.push_back(8'($urandom));
		chunk_q.push_back(FIXED_WORD[7:0]);
		chunk_q.push_back(FIXED_WORD[15:8]);
		for (int i = 0; i < 4; i++)
			chunk_q.push_back(flen[8 * i +: 8]);
		freal    = big_file ? $urandom_range(0, 12) : int'(flen);
		bom_mode = $urandom_range(0, 9);
		for (int i = 0; i < freal; i++) begin
			bv = 8'($urandom);
			if (bom_mode < 5 || (bom_mode < 7 && i < 2)) begin
				if (i == 0)
					bv = BOM_0;
				else if (i == 1)
					bv = BOM_1;
				else if (i == 2)
					bv = BOM_2;
			end
			chunk_q.push_back(bv);
		end
		if (big_file)
			return;
		repeat ((want_ok && flen == 0) ? $urandom_range(1, 4) : $urandom_range(0, 4))
			chunk_q.push_back(8'($urandom));
		if (want_ok)
			return;
		fault = $urandom_range(0, 99);
		cut   = chunk_q.size();
		if (fault < 55 && flen != 0) begin
			// ends inside the file, often while mark bytes are held
			if (flen >= 3 && $urandom_range(0, 2) == 0)
				cut = 17 + nreal + $urandom_range(1, 2);
			else
				cut = 17 + nreal + $urandom_range(0, int'(flen) - 1);
		end else if (fault < 72) begin
			idx = 11 + nreal + $urandom_range(0, 1);
			chunk_q[idx] = chunk_q[idx] ^ 8'($urandom_range(1, 255));
		end else if (fault < 88) begin
			idx = $urandom_range(0, 6);
			chunk_q[idx] = chunk_q[idx] ^ 8'($urandom_range(1, 255));
		end else begin
			cut = $urandom_range(1, 16 + nreal + int'(flen));
		end
		while (chunk_q.size() > cut)
			void'(chunk_q.pop_back());
	endtask

	initial
		result_ch.ready = 1'b0;

	// result checker and receiver stall pattern
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected item: kind %0d value %0h file_last %0d status %0d",
					result_ch.kind, result_ch.value, result_ch.file_last, result_ch.status);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (result_ch.kind !== want.kind) begin
					$error("kind: expected %0d, actual %0d", want.kind, result_ch.kind);
					errors++;
				end
				if (result_ch.value !== want.value) begin
					$error("value: expected %0h, actual %0h", want.value, result_ch.value);
					errors++;
				end
				if (result_ch.file_last !== want.file_last) begin
					$error("file_last: expected %0d, actual %0d", want.file_last,
						result_ch.file_last);
					errors++;
				end
				if (result_ch.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, result_ch.status);
					errors++;
				end
			end
		end
		stall_cyc++;
		if (stall_cyc % 97 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0:       result_ch.ready <= 1'b1;
			1:       result_ch.ready <= 1'($urandom_range(0, 1));
			2:       result_ch.ready <= (stall_cyc % 4) == 0;
			default: result_ch.ready <= (stall_cyc % 16) < 5;
		endcase
	end

	initial begin
		dir_row_t row;
		bit       ok_sent;
		int       chunk_no;
		int       wait_cyc;
		ok_sent  = 1'b0;
		chunk_no = 0;
		chunk_ch.valid     = 1'b0;
		chunk_ch.data_byte = 8'h00;
		chunk_ch.chunk_end = 1'b0;
		arst_n = 1'b0;
		clear_chunk_state();
		chunk_taken = 1'b0;
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			row = dir_row(i);
			send_item(row.data_byte, row.chunk_end, row.typed, row.status);
		end

		// broken chunks first, one good chunk late, then refused ones
		while (sent_items < DIR_ROWS + RAND_ITEMS) begin
			build_chunk(sent_items >= DIR_ROWS + 400 && !ok_sent);
			if (sent_items >= DIR_ROWS + 400)
				ok_sent = 1'b1;
			send_chunk();
			chunk_no++;
			if (chunk_no % 9 == 0) begin
				chunk_ch.valid <= 1'b0;
				do
					@(posedge clk);
				while (pending_results.size() != 0);
			end
		end
		chunk_ch.valid <= 1'b0;

		wait_cyc = 0;
		while (pending_results.size() != 0 && wait_cyc < 20000) begin
			@(posedge clk);
			wait_cyc++;
		end
		if (pending_results.size() != 0) begin
			$error("%0d expected items never arrived", pending_results.size());
			errors++;
		end
		repeat (20)
			@(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ gab2_subtitle_chunk_deframer.f @@
rtl/core/gab2d_pkg.sv
rtl/core/gab2d_if.sv
rtl/core/gab2d_in_reg.sv
rtl/core/gab2d_parse.sv
rtl/core/gab2d_out_buf.sv
rtl/core/gab2_subtitle_chunk_deframer.sv
bench/tb_gab2_subtitle_chunk_deframer.sv
